// ===== src/lcdw_pkg.sv =====
// ----------------------------------------------------------------------------
// lcdw_pkg
// Shared types, command codes and geometry constants of the LCD window writer.
// ----------------------------------------------------------------------------
`default_nettype none

package lcdw_pkg;

   // panel command codes
   localparam logic [31:0] CMD_MADCTL  = 32'h0000_0036;
   localparam logic [31:0] CMD_CASET   = 32'h0000_002A;
   localparam logic [31:0] CMD_RASET   = 32'h0000_002B;
   localparam logic [31:0] CMD_RAMCTRL = 32'h0000_00B0;
   localparam logic [31:0] CMD_RAMWR   = 32'h0000_002C;

   // operations handed from the front to the back
   localparam int OP_W = 3;
   localparam logic [OP_W-1:0] OP_MADCTL  = 3'd0;
   localparam logic [OP_W-1:0] OP_CASET   = 3'd1;
   localparam logic [OP_W-1:0] OP_RASET   = 3'd2;
   localparam logic [OP_W-1:0] OP_RAMCTRL = 3'd3;
   localparam logic [OP_W-1:0] OP_RAMWR   = 3'd4;

   // default skin size
   localparam int SKIN_COLS_DEF = 256;
   localparam int SKIN_ROWS_DEF = 512;

   // panel and skin offsets
   localparam int PORT_XOFF  = 52;
   localparam int PORT_YOFF  = 40;
   localparam int PORT_SXOFF = 62 / 2;
   localparam int PORT_SYOFF = 126 / 2;
   localparam int LAND_XOFF  = 40;
   localparam int LAND_YOFF  = 53;
   localparam int LAND_SXOFF = 126 / 2;
   localparam int LAND_SYOFF = 82 / 2;

   // csr map
   localparam int CSR_ADDR_W = 3;
   localparam logic CSR_IDX_BACKLIGHT = 1'b0;

   localparam int CUR_W  = 17;
   localparam int WIN_W  = 16;
   localparam int ADDR_W = 17;
   localparam int TERM_W = CUR_W + 2;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic [31:0]     word;
   } queue_entry_type;

endpackage

`default_nettype wire

// ===== src/lcd_spi_window_pixel_writer.sv =====
// ----------------------------------------------------------------------------
// lcd_spi_window_pixel_writer
// SPI command/data decoder that turns RAMWR words into framebuffer writes.
// ----------------------------------------------------------------------------
// The front takes one SPI transaction per cycle while the queue is not full
// and latches commands; data words under a known command go into a
// two-entry queue. The back applies window and mode updates and turns a
// RAMWR word into two pixel results (one if the first pixel closes the
// window) through the single cursor walk, popping the word after its last
// pixel. The cursor step and the row-times-pitch multiply happen in the same
// cycle into the s1 registers; the address add and bounds compare feed the
// output registers. The backlight register lies at byte address 0 of the csr
// port; the user must write it only while the block is idle; not enforced.
`default_nettype none

module lcd_spi_window_pixel_writer
   import lcdw_pkg::*;
#(
   parameter int SKIN_COLS = SKIN_COLS_DEF,
   parameter int SKIN_ROWS = SKIN_ROWS_DEF
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic                  req_kind,
   input  wire logic [31:0]           req_word,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic                       rsp_store_enable,
   output logic [ADDR_W-1:0]          rsp_address,
   output logic [23:0]                rsp_color,
   output logic                       rsp_frame_done,
   output logic                       rsp_last,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);

   logic            backlight_ff, backlight_in;
   logic            q_full;
   logic            q_valid;
   logic            push;
   logic            pop;
   queue_entry_type push_entry;
   queue_entry_type q_head;

   assign csr_pready = 1'b1;

   always_comb begin
      backlight_in = backlight_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
          csr_paddr[2] == CSR_IDX_BACKLIGHT) begin
         backlight_in = csr_pwdata[0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == CSR_IDX_BACKLIGHT) ? {31'd0, backlight_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         backlight_ff <= 1'b0;
      end else begin
         backlight_ff <= backlight_in;
      end
   end

   lcdw_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_kind   (req_kind),
      .req_word   (req_word),
      .q_full     (q_full),
      .push       (push),
      .push_entry (push_entry)
   );

   lcdw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .q_valid    (q_valid),
      .q_full     (q_full),
      .q_head     (q_head)
   );

   lcdw_back #(
      .SKIN_COLS (SKIN_COLS),
      .SKIN_ROWS (SKIN_ROWS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .backlight_on     (backlight_ff),
      .q_valid          (q_valid),
      .q_head           (q_head),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_store_enable (rsp_store_enable),
      .rsp_address      (rsp_address),
      .rsp_color        (rsp_color),
      .rsp_frame_done   (rsp_frame_done),
      .rsp_last         (rsp_last)
   );

   // a pixel that closes the window always ends its word
   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_done |-> rsp_last)
      else $error("frame_done without last");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_full || pop)
      else $error("queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> q_valid)
      else $error("queue underflow");

endmodule

`default_nettype wire

// ===== src/lcdw_front.sv =====
// ----------------------------------------------------------------------------
// lcdw_front
// Accepts SPI transactions, latches commands and queues the data words that act.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdw_front
   import lcdw_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire logic            req_kind,
   input  wire logic [31:0]     req_word,
   input  wire logic            q_full,
   output logic                 push,
   output queue_entry_type      push_entry
);

   logic [31:0] command_ff;
   logic [31:0] command_in;
   logic        accept;
   logic        known;
   logic [OP_W-1:0] op;

   assign req_stall = q_full;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      known = 1'b1;
      op    = OP_RAMWR;
      case (command_ff)
         CMD_MADCTL:  op = OP_MADCTL;
         CMD_CASET:   op = OP_CASET;
         CMD_RASET:   op = OP_RASET;
         CMD_RAMCTRL: op = OP_RAMCTRL;
         CMD_RAMWR:   op = OP_RAMWR;
         default:     known = 1'b0;
      endcase
   end

   always_comb begin
      command_in = command_ff;
      if (accept && req_kind) begin
         command_in = req_word;
      end
   end

   // data under an unknown command is dropped here
   assign push            = accept && !req_kind && known;
   assign push_entry.op   = op;
   assign push_entry.word = req_word;

   always_ff @(posedge clock) begin
      if (reset) begin
         command_ff <= '0;
      end else begin
         command_ff <= command_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/lcdw_queue.sv =====
// ----------------------------------------------------------------------------
// lcdw_queue
// Two-entry queue between the decode front and the pixel back.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdw_queue
   import lcdw_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            push,
   input  wire queue_entry_type push_entry,
   input  wire logic            pop,
   output logic                 q_valid,
   output logic                 q_full,
   output queue_entry_type      q_head
);

   queue_entry_type mem [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign q_valid = count_ff != 2'd0;
   assign q_full  = count_ff == 2'd2;
   assign q_head  = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/lcdw_back.sv =====
// ----------------------------------------------------------------------------
// lcdw_back
// Window state, cursor walk, pixel conversion and framebuffer address pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdw_back
   import lcdw_pkg::*;
#(
   parameter int SKIN_COLS = SKIN_COLS_DEF,
   parameter int SKIN_ROWS = SKIN_ROWS_DEF
)
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              backlight_on,
   input  wire logic              q_valid,
   input  wire queue_entry_type   q_head,
   output logic                   pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic                   rsp_store_enable,
   output logic [ADDR_W-1:0]      rsp_address,
   output logic [23:0]            rsp_color,
   output logic                   rsp_frame_done,
   output logic                   rsp_last
);

   localparam int PITCH_MAX = (SKIN_COLS > SKIN_ROWS) ? SKIN_COLS : SKIN_ROWS;
   localparam int PITCH_W   = $clog2(PITCH_MAX + 1) + 1;
   localparam int PROD_W    = TERM_W + PITCH_W;
   localparam int SUM_W     = PROD_W + 1;
   localparam int FB_WORDS  = SKIN_COLS * SKIN_ROWS;

   localparam logic signed [TERM_W-1:0] ROW_ADJ_P = TERM_W'(PORT_SYOFF - PORT_YOFF);
   localparam logic signed [TERM_W-1:0] ROW_ADJ_L = TERM_W'(LAND_SYOFF - LAND_YOFF);
   localparam logic signed [TERM_W-1:0] COL_ADJ_P = TERM_W'(PORT_SXOFF - PORT_XOFF);
   localparam logic signed [TERM_W-1:0] COL_ADJ_L = TERM_W'(LAND_SXOFF - LAND_XOFF);
   localparam logic signed [PITCH_W-1:0] PITCH_P  = PITCH_W'(SKIN_COLS);
   localparam logic signed [PITCH_W-1:0] PITCH_L  = PITCH_W'(SKIN_ROWS);
   localparam logic signed [SUM_W-1:0]   FB_LIMIT = SUM_W'(FB_WORDS);

   function automatic logic [15:0] swap_half(input logic [15:0] h);
      swap_half = {h[7:0], h[15:8]};
   endfunction

   // window and mode state
   logic               portrait_ff, portrait_in;
   logic               little_ff, little_in;
   logic [WIN_W-1:0]   col_start_ff, col_start_in;
   logic [WIN_W-1:0]   col_end_ff, col_end_in;
   logic [WIN_W-1:0]   row_start_ff, row_start_in;
   logic [WIN_W-1:0]   row_end_ff, row_end_in;
   logic [CUR_W-1:0]   col_cur_ff, col_cur_in;
   logic [CUR_W-1:0]   row_cur_ff, row_cur_in;
   logic               pix_sel_ff, pix_sel_in;

   // address stage
   logic                     s1_valid_ff, s1_valid_in;
   logic signed [PROD_W-1:0] s1_prod_ff, s1_prod_in;
   logic signed [TERM_W-1:0] s1_colterm_ff, s1_colterm_in;
   logic [23:0]              s1_color_ff, s1_color_in;
   logic                     s1_done_ff, s1_done_in;
   logic                     s1_last_ff, s1_last_in;

   logic                     advance;
   logic                     go;
   logic                     emit;
   logic [15:0]              d16;
   logic [23:0]              rgb;
   logic [CUR_W-1:0]         col_step, row_step;
   logic                     done;
   logic signed [TERM_W-1:0] rowterm;
   logic signed [PITCH_W-1:0] pitch;
   logic signed [SUM_W-1:0]  sum;

   assign advance = !rsp_valid || !rsp_stall;
   assign go      = advance && q_valid;

   // pixel conversion
   always_comb begin
      d16 = pix_sel_ff ? q_head.word[31:16] : q_head.word[15:0];
      if (!little_ff) begin
         d16 = swap_half(d16);
      end
      rgb = {d16[15:11], 3'b000, d16[10:5], 2'b00, d16[4:0], 3'b000};
      if (!backlight_on) begin
         rgb = {2'b00, rgb[23:18], 2'b00, rgb[15:10], 2'b00, rgb[7:2]};
      end
   end

   // cursor walk for one pixel
   always_comb begin
      col_step = col_cur_ff + CUR_W'(1);
      row_step = row_cur_ff;
      done     = 1'b0;
      if (col_step > {1'b0, col_end_ff}) begin
         col_step = {1'b0, col_start_ff};
         row_step = row_cur_ff + CUR_W'(1);
      end
      if (row_step > {1'b0, row_end_ff}) begin
         row_step = {1'b0, row_start_ff};
         col_step = {1'b0, col_start_ff};
         done     = 1'b1;
      end
   end

   always_comb begin
      portrait_in  = portrait_ff;
      little_in    = little_ff;
      col_start_in = col_start_ff;
      col_end_in   = col_end_ff;
      row_start_in = row_start_ff;
      row_end_in   = row_end_ff;
      col_cur_in   = col_cur_ff;
      row_cur_in   = row_cur_ff;
      pix_sel_in   = pix_sel_ff;
      pop          = 1'b0;
      emit         = 1'b0;
      if (go) begin
         pop = 1'b1;
         case (q_head.op)
            OP_MADCTL: begin
               portrait_in = (q_head.word == 32'd0) || (q_head.word == 32'd8);
            end
            OP_CASET: begin
               col_start_in = swap_half(q_head.word[15:0]);
               col_end_in   = swap_half(q_head.word[31:16]);
               col_cur_in   = {1'b0, swap_half(q_head.word[15:0])};
            end
            OP_RASET: begin
               row_start_in = swap_half(q_head.word[15:0]);
               row_end_in   = swap_half(q_head.word[31:16]);
               row_cur_in   = {1'b0, swap_half(q_head.word[15:0])};
            end
            OP_RAMCTRL: begin
               little_in = q_head.word[11];
            end
            OP_RAMWR: begin
               emit       = 1'b1;
               col_cur_in = col_step;
               row_cur_in = row_step;
               // first pixel stays at the head unless it closed the window
               if (!pix_sel_ff && !done) begin
                  pix_sel_in = 1'b1;
                  pop        = 1'b0;
               end else begin
                  pix_sel_in = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // row term times pitch, registered before the add
   always_comb begin
      rowterm = $signed({2'b00, row_cur_ff}) + (portrait_ff ? ROW_ADJ_P : ROW_ADJ_L);
      pitch   = portrait_ff ? PITCH_P : PITCH_L;
      s1_prod_in    = PROD_W'(rowterm * pitch);
      s1_colterm_in = $signed({2'b00, col_cur_ff}) + (portrait_ff ? COL_ADJ_P : COL_ADJ_L);
      s1_color_in   = rgb;
      s1_done_in    = done;
      s1_last_in    = done || pix_sel_ff;
      s1_valid_in   = emit;
   end

   assign sum = SUM_W'(s1_prod_ff) + SUM_W'(s1_colterm_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         portrait_ff  <= 1'b0;
         little_ff    <= 1'b0;
         col_start_ff <= '0;
         col_end_ff   <= '0;
         row_start_ff <= '0;
         row_end_ff   <= '0;
         col_cur_ff   <= '0;
         row_cur_ff   <= '0;
         pix_sel_ff   <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid    <= 1'b0;
      end else begin
         portrait_ff  <= portrait_in;
         little_ff    <= little_in;
         col_start_ff <= col_start_in;
         col_end_ff   <= col_end_in;
         row_start_ff <= row_start_in;
         row_end_ff   <= row_end_in;
         col_cur_ff   <= col_cur_in;
         row_cur_ff   <= row_cur_in;
         pix_sel_ff   <= pix_sel_in;
         if (advance) begin
            s1_valid_ff <= s1_valid_in;
            rsp_valid   <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_prod_ff       <= s1_prod_in;
         s1_colterm_ff    <= s1_colterm_in;
         s1_color_ff      <= s1_color_in;
         s1_done_ff       <= s1_done_in;
         s1_last_ff       <= s1_last_in;
         rsp_store_enable <= !sum[SUM_W-1] && (sum < FB_LIMIT);
         rsp_address      <= sum[ADDR_W-1:0];
         rsp_color        <= s1_color_ff;
         rsp_frame_done   <= s1_done_ff;
         rsp_last         <= s1_last_ff;
      end
   end

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the LCD window writer: SPI command and data words
// go in with random gaps, framebuffer writes come out under random stalls and
// are compared with a cycle-free model of the panel window walk.
// ----------------------------------------------------------------------------

module tb_top;
   import lcdw_pkg::*;

   localparam int LIMIT      = 400000;
   localparam int SETTLE     = 16;
   localparam int PHASE_WORDS = 440;
   localparam logic [CSR_ADDR_W-1:0] BACKLIGHT_ADDR = CSR_ADDR_W'(4 * CSR_IDX_BACKLIGHT);

   typedef struct packed {
      logic              store_enable;
      logic [ADDR_W-1:0] address;
      logic [23:0]       color;
      logic              frame_done;
      logic              last;
   } pixel_wr_type;

   // one directed transaction; typed rows carry their own expectation
   typedef struct packed {
      logic         kind;
      logic [31:0]  word;
      logic         typed;
      logic         one;
      pixel_wr_type pix;
   } row_type;

   localparam pixel_wr_type NO_PIX = '0;
   localparam int PLAN_ROWS = 26;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              req_valid = 1'b0;
   logic              req_stall;
   logic              req_kind = 1'b0;
   logic [31:0]       req_word = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic              rsp_store_enable;
   logic [ADDR_W-1:0] rsp_address;
   logic [23:0]       rsp_color;
   logic              rsp_frame_done;
   logic              rsp_last;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0]           csr_pwdata = '0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   // panel state as the block should hold it
   logic [31:0]      cmd_latch = '0;
   logic             portrait = 1'b0;
   logic             byte_order_le = 1'b0;
   logic [WIN_W-1:0] col_lo = '0, col_hi = '0, row_lo = '0, row_hi = '0;
   logic [CUR_W-1:0] col_pos = '0, row_pos = '0;
   logic             backlight = 1'b0;

   pixel_wr_type word_writes[$];
   pixel_wr_type pending_writes[$];

   int          mismatches = 0;
   int unsigned cycles = 0;
   logic        no_gaps = 1'b0;

   row_type plan [PLAN_ROWS] = '{
      '{1'b0, 32'h1234_5678, 1'b1, 1'b0, NO_PIX},   // data with nothing latched
      '{1'b1, CMD_RAMWR,     1'b1, 1'b0, NO_PIX},
      // reset window is one pixel: wraps at once, off the framebuffer, dimmed
      '{1'b0, 32'hFFFF_FFFF, 1'b1, 1'b1, '{1'b0, 17'h1E817, 24'h3E3F3E, 1'b1, 1'b1}},
      '{1'b0, 32'h0000_0000, 1'b0, 1'b0, NO_PIX},
      '{1'b1, CMD_MADCTL,    1'b1, 1'b0, NO_PIX},
      '{1'b0, 32'h0000_0008, 1'b1, 1'b0, NO_PIX},   // portrait
      '{1'b1, CMD_CASET,     1'b1, 1'b0, NO_PIX},
      '{1'b0, 32'h3D00_3C00, 1'b1, 1'b0, NO_PIX},   // columns 60..61
      '{1'b1, CMD_RASET,     1'b1, 1'b0, NO_PIX},
      '{1'b0, 32'h6500_6400, 1'b1, 1'b0, NO_PIX},   // rows 100..101
      '{1'b1, CMD_RAMWR,     1'b1, 1'b0, NO_PIX},
      '{1'b0, 32'h1234_ABCD, 1'b0, 1'b0, NO_PIX},   // row advance, no wrap
      '{1'b1, CMD_RAMCTRL,   1'b1, 1'b0, NO_PIX},
      '{1'b0, 32'h0000_0800, 1'b1, 1'b0, NO_PIX},   // little endian
      '{1'b1, CMD_RAMWR,     1'b1, 1'b0, NO_PIX},
      '{1'b0, 32'hF800_07E0, 1'b0, 1'b0, NO_PIX},   // window wrap on second pixel
      '{1'b1, CMD_MADCTL,    1'b1, 1'b0, NO_PIX},
      '{1'b0, 32'h0000_0000, 1'b1, 1'b0, NO_PIX},
      '{1'b1, CMD_CASET,     1'b1, 1'b0, NO_PIX},
      '{1'b0, 32'h0000_FFFF, 1'b1, 1'b0, NO_PIX},   // start past end
      '{1'b1, CMD_RAMWR,     1'b1, 1'b0, NO_PIX},
      '{1'b0, 32'h07E0_F81F, 1'b0, 1'b0, NO_PIX},
      '{1'b1, 32'hFFFF_FFFF, 1'b1, 1'b0, NO_PIX},   // unknown command
      '{1'b0, 32'hAAAA_5555, 1'b1, 1'b0, NO_PIX},
      '{1'b1, CMD_MADCTL,    1'b1, 1'b0, NO_PIX},
      '{1'b0, 32'hFFFF_FFFF, 1'b1, 1'b0, NO_PIX}    // back to landscape
   };

   lcd_spi_window_pixel_writer dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_word         (req_word),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_store_enable (rsp_store_enable),
      .rsp_address      (rsp_address),
      .rsp_color        (rsp_color),
      .rsp_frame_done   (rsp_frame_done),
      .rsp_last         (rsp_last),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   always #1 clock = ~clock;

   function automatic logic coin_gap();
      return !no_gaps && ($urandom_range(99) < 7);
   endfunction

   // fills word_writes with the framebuffer writes one SPI word causes
   function automatic void step_panel(input logic kind, input logic [31:0] word);
      logic [15:0]  d16;
      logic [23:0]  rgb;
      logic [31:0]  xo, yo, sxo, syo, pitch, addr;
      logic         done;
      pixel_wr_type wr;
      word_writes.delete();
      if (kind) begin
         cmd_latch = word;
         return;
      end
      case (cmd_latch)
         CMD_MADCTL: begin
            portrait = (word == 32'd0 || word == 32'd8);
         end
         CMD_CASET: begin
            col_lo  = {word[7:0], word[15:8]};
            col_hi  = {word[23:16], word[31:24]};
            col_pos = {1'b0, col_lo};
         end
         CMD_RASET: begin
            row_lo  = {word[7:0], word[15:8]};
            row_hi  = {word[23:16], word[31:24]};
            row_pos = {1'b0, row_lo};
         end
         CMD_RAMCTRL: begin
            byte_order_le = word[11];
         end
         CMD_RAMWR: begin
            if (portrait) begin
               xo = PORT_XOFF; yo = PORT_YOFF; sxo = PORT_SXOFF; syo = PORT_SYOFF;
               pitch = SKIN_COLS_DEF;
            end else begin
               xo = LAND_XOFF; yo = LAND_YOFF; sxo = LAND_SXOFF; syo = LAND_SYOFF;
               pitch = SKIN_ROWS_DEF;
            end
            for (int i = 0; i < 2; i++) begin
               d16 = (i == 0) ? word[15:0] : word[31:16];
               if (!byte_order_le) d16 = {d16[7:0], d16[15:8]};
               rgb = {d16[15:11], 3'b0, d16[10:5], 2'b0, d16[4:0], 3'b0};
               if (!backlight) rgb = (rgb >> 2) & 24'h3F3F3F;
               // address wraps at 32 bits before the 17-bit cut
               addr = (32'(row_pos) - yo + syo) * pitch + 32'(col_pos) - xo + sxo;
               done = 1'b0;
               col_pos = col_pos + 1'b1;
               if (col_pos > {1'b0, col_hi}) begin
                  col_pos = {1'b0, col_lo};
                  row_pos = row_pos + 1'b1;
               end
               if (row_pos > {1'b0, row_hi}) begin
                  row_pos = {1'b0, row_lo};
                  col_pos = {1'b0, col_lo};
                  done = 1'b1;
               end
               wr.store_enable = addr < 32'(SKIN_COLS_DEF * SKIN_ROWS_DEF);
               wr.address      = addr[ADDR_W-1:0];
               wr.color        = rgb;
               wr.frame_done   = done;
               wr.last         = done || (i == 1);
               word_writes.push_back(wr);
               if (done) break;
            end
         end
         default: ;
      endcase
   endfunction

   task automatic report(input string what, input pixel_wr_type want,
                         input pixel_wr_type got);
      if (mismatches < 10)
         $display({"%s: want en=%b addr=%h color=%h done=%b last=%b,",
                   " got en=%b addr=%h color=%h done=%b last=%b"},
                  what, want.store_enable, want.address, want.color, want.frame_done,
                  want.last, got.store_enable, got.address, got.color,
                  got.frame_done, got.last);
      mismatches++;
   endtask

   // called at a falling edge, returns at a falling edge
   task automatic send_item(input logic kind, input logic [31:0] word,
                            input logic typed = 1'b0, input logic one = 1'b0,
                            input pixel_wr_type pix = '0);
      while (coin_gap()) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_kind  <= kind;
      req_word  <= word;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      step_panel(kind, word);
      if (typed) begin
         if (one) pending_writes.push_back(pix);
      end else begin
         foreach (word_writes[j]) pending_writes.push_back(word_writes[j]);
      end
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_writes.size() != 0) @(negedge clock);
      // ignored words may still sit in the block with nothing to wait for
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_backlight(input logic on);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= BACKLIGHT_ADDR;
      csr_pwdata  <= 32'(on);
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      backlight = on;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   function automatic logic [31:0] window_word();
      logic [15:0] lo, hi;
      case ($urandom_range(9))
         0: begin
            lo = 16'($urandom);
            hi = 16'($urandom);
         end
         1: begin
            hi = 16'($urandom_range(0, 299));
            lo = hi + 16'($urandom_range(1, 40));
         end
         default: begin
            lo = 16'($urandom_range(0, 300));
            hi = lo + 16'($urandom_range(0, 7));
         end
      endcase
      return {hi[7:0], hi[15:8], lo[7:0], lo[15:8]};
   endfunction

   // mostly well-formed command/data pairs and pixel bursts, some noise
   task automatic run_traffic(input int goal);
      int          sent;
      int          pick;
      int          burst;
      logic        kind;
      logic [31:0] w;
      sent = 0;
      while (sent < goal) begin
         pick = $urandom_range(99);
         if (pick < 40) begin
            burst = $urandom_range(1, 20);
            send_item(1'b1, CMD_RAMWR);
            repeat (burst) send_item(1'b0, $urandom);
            sent += burst + 1;
         end else if (pick < 55) begin
            send_item(1'b1, CMD_CASET);
            send_item(1'b0, window_word());
            sent += 2;
         end else if (pick < 70) begin
            send_item(1'b1, CMD_RASET);
            send_item(1'b0, window_word());
            sent += 2;
         end else if (pick < 78) begin
            pick = $urandom_range(2);
            w = (pick == 0) ? 32'd0 : (pick == 1) ? 32'd8 : $urandom;
            send_item(1'b1, CMD_MADCTL);
            send_item(1'b0, w);
            sent += 2;
         end else if (pick < 86) begin
            send_item(1'b1, CMD_RAMCTRL);
            send_item(1'b0, $urandom);
            sent += 2;
         end else begin
            case ($urandom_range(2))
               0:       w = $urandom;
               1:       w = CMD_RAMWR ^ (32'd1 << $urandom_range(31));
               default: w = 32'($urandom_range(255));
            endcase
            kind = 1'($urandom_range(1));
            send_item(kind, w);
            if (kind) sent++;
         end
      end
   endtask

   always @(negedge clock) begin
      rsp_stall <= coin_gap();
   end

   always @(posedge clock) begin : check_writes
      pixel_wr_type got, want;
      got = {rsp_store_enable, rsp_address, rsp_color, rsp_frame_done, rsp_last};
      if (!reset && $isunknown(rsp_valid)) begin
         report("unknown valid", NO_PIX, got);
      end else if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_writes.size() == 0) begin
            report("unexpected write", NO_PIX, got);
         end else begin
            want = pending_writes.pop_front();
            if (got !== want) report("write mismatch", want, got);
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles == LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (plan[k])
         send_item(plan[k].kind, plan[k].word, plan[k].typed, plan[k].one, plan[k].pix);
      for (int ph = 0; ph < 4; ph++) begin
         drain();
         write_backlight(ph % 2 == 0);
         no_gaps <= (ph == 2);
         run_traffic(PHASE_WORDS);
      end
      no_gaps <= 1'b0;
      drain();
      if (pending_writes.size() != 0) mismatches++;
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
